// ===== src/assert_macros.svh =====
// assertion macros shared by the ranking block
// no dependencies; modules using them provide clock and reset signals
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, suspended while reset is high
`define TEI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked property, also during reset
`define TEI_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/tei_pkg.sv =====
// shared constants and types of the top eight index selector
// no dependencies
package tei_pkg;

   localparam int MAX_LEN   = 32;
   localparam int TOP_COUNT = 8;

   localparam int VALUE_W = 16;
   localparam int POS_W   = 5;
   localparam int RANK_W  = 3;
   localparam int CNT_W   = $clog2(MAX_LEN + 1);
   localparam int RIDX_W  = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

   // controller modes
   typedef enum logic {
      ST_COLLECT,
      ST_DRAIN
   } tei_state_type;

   // per-cycle commands broadcast to every cell
   typedef struct packed {
      logic load_first;
      logic rank_en;
      logic shift_up;
   } tei_ctl_type;

endpackage

// ===== src/tei_cell.sv =====
// one ranked slot of the chain: holds a position and a value
// depends on tei_pkg
module tei_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  tei_pkg::tei_ctl_type         ctl,
   input  logic [tei_pkg::POS_W-1:0]    new_pos,
   input  logic [tei_pkg::VALUE_W-1:0]  new_val,
   input  logic                         up_gt,
   input  logic [tei_pkg::POS_W-1:0]    up_pos,
   input  logic [tei_pkg::VALUE_W-1:0]  up_val,
   input  logic [tei_pkg::POS_W-1:0]    down_pos,
   input  logic [tei_pkg::VALUE_W-1:0]  down_val,
   output logic                         gt,
   output logic [tei_pkg::POS_W-1:0]    pos,
   output logic [tei_pkg::VALUE_W-1:0]  val
);
   import tei_pkg::*;

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [VALUE_W-1:0] val_ff, val_in;

   // new word beats this slot
   assign gt = new_val > val_ff;

   // next slot contents
   always_comb begin
      pos_in = pos_ff;
      val_in = val_ff;
      if (ctl.load_first) begin
         pos_in = new_pos;
         val_in = new_val;
      end else if (ctl.rank_en) begin
         if (up_gt) begin
            pos_in = up_pos;
            val_in = up_val;
         end else if (gt) begin
            pos_in = new_pos;
            val_in = new_val;
         end
      end else if (ctl.shift_up) begin
         pos_in = down_pos;
         val_in = down_val;
      end
   end

   // slot registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         val_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         val_ff <= val_in;
      end
   end

   assign pos = pos_ff;
   assign val = val_ff;

endmodule

// ===== src/tei_ctrl.sv =====
// list counter and drain sequencer for the ranking chain
// depends on tei_pkg and assert_macros.svh
`include "assert_macros.svh"

module tei_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_end_of_list,
   input  logic                        rsp_stall,
   output logic                        req_stall,
   output logic                        rsp_valid,
   output logic [tei_pkg::RANK_W-1:0]  rsp_rank,
   output logic                        rsp_last_result,
   output logic [tei_pkg::POS_W-1:0]   new_pos,
   output tei_pkg::tei_ctl_type        ctl
);
   import tei_pkg::*;

   tei_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [RIDX_W-1:0] rank_ff, rank_in;
   logic              req_acc;
   logic              last_rank;

   assign req_acc   = req_valid && !req_stall;
   assign last_rank = rank_ff == RIDX_W'(TOP_COUNT - 1);
   assign new_pos   = POS_W'(count_ff);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         count_ff <= '0;
         rank_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rank_ff  <= rank_in;
      end
   end

   // next state and cell commands
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      rank_in        = rank_ff;
      ctl            = '0;
      req_stall      = 1'b0;
      rsp_valid      = 1'b0;
      case (state_ff)
         ST_COLLECT: begin
            if (req_acc) begin
               if (count_ff == '0) begin
                  ctl.load_first = 1'b1;
               end else if (count_ff < CNT_W'(MAX_LEN)) begin
                  ctl.rank_en = 1'b1;
               end
               if (req_end_of_list) begin
                  state_in = ST_DRAIN;
                  count_in = '0;
                  rank_in  = '0;
               end else if (count_ff < CNT_W'(MAX_LEN)) begin
                  count_in = CNT_W'(count_ff + 1'b1);
               end
            end
         end
         ST_DRAIN: begin
            req_stall = 1'b1;
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               // rank 0 leaves, the rest move up and zeros enter at the bottom
               ctl.shift_up = 1'b1;
               rank_in      = RIDX_W'(rank_ff + 1'b1);
               if (last_rank) begin
                  state_in = ST_COLLECT;
                  rank_in  = '0;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   assign rsp_rank        = RANK_W'(rank_ff);
   assign rsp_last_result = last_rank;

   `TEI_ASSERT_ALWAYS(a_ctl_onehot, $onehot0(ctl), "more than one cell command at once")
   `TEI_ASSERT(a_eol_drains, req_acc && req_end_of_list |=> rsp_valid && rsp_rank == '0,
      "end of list did not start the drain at rank 0")
   `TEI_ASSERT(a_drain_ends, rsp_valid && !rsp_stall && rsp_last_result |=> !rsp_valid,
      "drain did not stop after the last word")
   `TEI_ASSERT(a_count_bound, count_ff <= CNT_W'(MAX_LEN), "list counter beyond limit")

endmodule

// ===== src/top_eight_index_selector.sv =====
// Latency: the rank 0 word is offered the cycle after the end-of-list word is accepted.
// Throughput: one list word per cycle while collecting; after end of list the input stalls
// until the chain has shifted all TOP_COUNT results out through rank 0, and output stalls prolong this.
// Reset clears every slot, the list counter and the drain sequencer.
// Top level: chain of TOP_COUNT ranking cells plus controller; depends on tei_pkg,
// tei_cell and tei_ctrl
module top_eight_index_selector (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tei_pkg::VALUE_W-1:0]   req_count_value,
   input  logic                          req_end_of_list,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tei_pkg::RANK_W-1:0]    rsp_rank,
   output logic [tei_pkg::POS_W-1:0]     rsp_position,
   output logic [tei_pkg::VALUE_W-1:0]   rsp_slot_value,
   output logic                          rsp_last_result
);
   import tei_pkg::*;

   tei_ctl_type        ctl;
   logic [POS_W-1:0]   new_pos;
   logic               cell_gt  [TOP_COUNT];
   logic [POS_W-1:0]   cell_pos [TOP_COUNT];
   logic [VALUE_W-1:0] cell_val [TOP_COUNT];

   // controller
   tei_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_end_of_list (req_end_of_list),
      .rsp_stall       (rsp_stall),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_rank        (rsp_rank),
      .rsp_last_result (rsp_last_result),
      .new_pos         (new_pos),
      .ctl             (ctl)
   );

   // chain of ranked slots, rank 0 at the head
   for (genvar k = 0; k < TOP_COUNT; k++) begin : g_cell
      logic               up_gt;
      logic [POS_W-1:0]   up_pos, down_pos;
      logic [VALUE_W-1:0] up_val, down_val;

      if (k == 0) begin : g_head
         assign up_gt  = 1'b0;
         assign up_pos = '0;
         assign up_val = '0;
      end else begin : g_mid
         assign up_gt  = cell_gt[k-1];
         assign up_pos = cell_pos[k-1];
         assign up_val = cell_val[k-1];
      end

      if (k == TOP_COUNT - 1) begin : g_tail
         assign down_pos = '0;
         assign down_val = '0;
      end else begin : g_body
         assign down_pos = cell_pos[k+1];
         assign down_val = cell_val[k+1];
      end

      tei_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .new_pos  (new_pos),
         .new_val  (req_count_value),
         .up_gt    (up_gt),
         .up_pos   (up_pos),
         .up_val   (up_val),
         .down_pos (down_pos),
         .down_val (down_val),
         .gt       (cell_gt[k]),
         .pos      (cell_pos[k]),
         .val      (cell_val[k])
      );
   end

   // result word comes from the head slot
   assign rsp_position   = cell_pos[0];
   assign rsp_slot_value = cell_val[0];

endmodule

// ===== verif/top_eight_index_selector_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for top_eight_index_selector: random and directed count lists
// predicts the eight ranked slot words per list and checks them in order; depends on tei_pkg
module top_eight_index_selector_tb;
   import tei_pkg::*;

   // expected slot word on the result channel
   typedef struct {
      logic [RANK_W-1:0]  rank;
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] slot_value;
      logic               last_result;
   } slot_word_type;

   // how the counts of a random list are drawn
   typedef enum int {
      MIX_FULL,
      MIX_TIES,
      MIX_EXTREME,
      MIX_RISING
   } count_mix_type;

   // running top-eight ranking of the current list plus the queue of slot words due
   class top_eight_tracker;
      logic [POS_W-1:0]   held_position[TOP_COUNT];
      logic [VALUE_W-1:0] held_value[TOP_COUNT];
      int                 list_index;
      slot_word_type      due_slots[$];
      int                 failures;

      function new();
         clear_list();
         failures = 0;
      endfunction

      function void clear_list();
         for (int k = 0; k < TOP_COUNT; k++) begin
            held_position[k] = '0;
            held_value[k]    = '0;
         end
         list_index = 0;
      endfunction

      // rank one accepted list word; on end of list queue the eight slots and clear
      function void note_word(logic [VALUE_W-1:0] count_value, logic end_of_list);
         slot_word_type sw;
         int            slot;
         slot = -1;
         if (list_index < MAX_LEN) begin
            if (list_index == 0) begin
               // first word fills every slot
               for (int k = 0; k < TOP_COUNT; k++) begin
                  held_position[k] = '0;
                  held_value[k]    = count_value;
               end
            end else begin
               // insert above the first slot it strictly beats, ties keep the older word
               for (int k = 0; k < TOP_COUNT; k++) begin
                  if (slot < 0 && count_value > held_value[k])
                     slot = k;
               end
               if (slot >= 0) begin
                  for (int j = TOP_COUNT - 1; j > slot; j--) begin
                     held_position[j] = held_position[j-1];
                     held_value[j]    = held_value[j-1];
                  end
                  held_position[slot] = list_index[POS_W-1:0];
                  held_value[slot]    = count_value;
               end
            end
            list_index++;
         end
         if (end_of_list) begin
            for (int k = 0; k < TOP_COUNT; k++) begin
               sw.rank        = k[RANK_W-1:0];
               sw.position    = held_position[k];
               sw.slot_value  = held_value[k];
               sw.last_result = (k == TOP_COUNT - 1);
               due_slots.push_back(sw);
            end
            clear_list();
         end
      endfunction

      // compare one accepted result word with the oldest due slot
      function void check_word(logic [RANK_W-1:0] rank, logic [POS_W-1:0] position,
                               logic [VALUE_W-1:0] slot_value, logic last_result);
         slot_word_type sw;
         if (due_slots.size() == 0) begin
            $error("unexpected result word: rank %0d position %0d slot_value %0d",
                   rank, position, slot_value);
            failures++;
            return;
         end
         sw = due_slots.pop_front();
         if (rank !== sw.rank) begin
            $error("rank mismatch: expected %0d, actual %0d", sw.rank, rank);
            failures++;
         end
         if (position !== sw.position) begin
            $error("position mismatch: expected %0d, actual %0d", sw.position, position);
            failures++;
         end
         if (slot_value !== sw.slot_value) begin
            $error("slot_value mismatch: expected %0d, actual %0d",
                   sw.slot_value, slot_value);
            failures++;
         end
         if (last_result !== sw.last_result) begin
            $error("last_result mismatch: expected %0d, actual %0d",
                   sw.last_result, last_result);
            failures++;
         end
      endfunction

      function int pending();
         return due_slots.size();
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 200000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [VALUE_W-1:0] req_count_value = '0;
   logic               req_end_of_list = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [RANK_W-1:0]  rsp_rank;
   logic [POS_W-1:0]   rsp_position;
   logic [VALUE_W-1:0] rsp_slot_value;
   logic               rsp_last_result;

   top_eight_tracker tracker;
   int               req_idle_pct = 25;
   int               rsp_stall_pct = 57;
   int               hold_request = 0;
   int               hold_left = 0;
   int               cycle_count = 0;

   top_eight_index_selector dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_count_value (req_count_value),
      .req_end_of_list (req_end_of_list),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_rank        (rsp_rank),
      .rsp_position    (rsp_position),
      .rsp_slot_value  (rsp_slot_value),
      .rsp_last_result (rsp_last_result)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** top_eight_index_selector: FAILED **");
         $finish;
      end
   end

   // receiver stall: random, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_word(rsp_rank, rsp_position, rsp_slot_value, rsp_last_result);
   end

   // offer one list word, with random idle cycles ahead of it
   task automatic send_word(input logic [VALUE_W-1:0] count_value, input logic end_of_list);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_count_value <= count_value;
      req_end_of_list <= end_of_list;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      tracker.note_word(count_value, end_of_list);
   endtask

   function automatic logic [VALUE_W-1:0] pick_count(count_mix_type mix, int idx);
      case (mix)
         MIX_TIES:    return VALUE_W'($urandom_range(3));
         MIX_EXTREME: begin
            case ($urandom_range(2))
               0:       return '0;
               1:       return '1;
               default: return VALUE_W'($urandom_range(65535));
            endcase
         end
         MIX_RISING:  return VALUE_W'(idx * 1500 + $urandom_range(1499));
         default:     return VALUE_W'($urandom_range(65535));
      endcase
   endfunction

   // random list: mostly short, sometimes past the length limit
   task automatic send_random_list(output int words);
      count_mix_type mix;
      if ($urandom_range(99) < 15) begin
         words = $urandom_range(MAX_LEN + 8, MAX_LEN - 4);
         mix = ($urandom_range(1) == 0) ? MIX_RISING : count_mix_type'($urandom_range(2));
      end else begin
         words = $urandom_range(10, 1);
         mix = count_mix_type'($urandom_range(3));
      end
      for (int i = 0; i < words; i++)
         send_word(pick_count(mix, i), i == words - 1);
   endtask

   task automatic wait_drained();
      while (tracker.pending() != 0) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   initial begin
      int phase_words;
      int list_no;
      int words;
      tracker = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed lists: single words at both extremes, ties, rising and falling runs
      send_word('0, 1'b1);
      send_word('1, 1'b1);
      send_word(16'd5, 1'b0);
      send_word(16'd5, 1'b0);
      send_word(16'd5, 1'b1);
      for (int i = 1; i <= 9; i++)
         send_word(VALUE_W'(i), i == 9);
      send_word('1, 1'b0);
      send_word(16'd40000, 1'b0);
      send_word(16'd30000, 1'b0);
      send_word(16'd100, 1'b1);
      send_word('0, 1'b0);
      send_word('1, 1'b0);
      send_word(16'h8000, 1'b0);
      send_word('1, 1'b1);

      // random lists under three idle patterns
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct  = 25;
               rsp_stall_pct = 57;
            end
            1: begin
               req_idle_pct  = 57;
               rsp_stall_pct = 25;
            end
            default: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
         endcase
         phase_words = 0;
         list_no = 0;
         while (phase_words < 100) begin
            // long receiver hold-off while the sender keeps offering words
            if (phase == 0 && list_no == 2)
               hold_request = 200;
            // sender waits for every slot word to come out
            if (phase == 1 && list_no == 3)
               wait_drained();
            send_random_list(words);
            phase_words += words;
            list_no++;
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (tracker.failures == 0)
         $display("** top_eight_index_selector: PASSED **");
      else
         $display("** top_eight_index_selector: FAILED **");
      $finish;
   end

endmodule
